// ===== rtl/bfa_pkg.sv =====
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int DEF_STORE_BYTES    = 4096;
  localparam int DEF_MAX_FIELD_BITS = 32;

  localparam int OFFSET_W   = 15;
  localparam int FWIDTH_W   = 6;
  localparam int VALUE_W    = 32;
  localparam int NEXT_W     = 16;
  localparam int SHIFT_W    = 7;
  localparam int WORD_IDX_W = OFFSET_W - 5;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // classified access, handed from front end to back end
  typedef struct packed {
    logic                  kind;
    logic                  oor;
    logic                  sat;
    logic [FWIDTH_W-1:0]   width;
    logic [SHIFT_W-1:0]    shift;
    logic [VALUE_W-1:0]    value;
    logic [WORD_IDX_W-1:0] word;
    logic [NEXT_W-1:0]     next_offset;
  } bfa_cmd_t;

endpackage

// ===== rtl/bfa_if.sv =====
`timescale 1ns / 1ps
interface bfa_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [bfa_pkg::OFFSET_W-1:0]    bit_offset;
  logic [bfa_pkg::FWIDTH_W-1:0]    field_width;
  logic [bfa_pkg::VALUE_W-1:0]     write_value;

  modport source (output valid, kind, bit_offset, field_width, write_value, input ready);
  modport sink (input valid, kind, bit_offset, field_width, write_value, output ready);
endinterface

interface bfa_out_if;
  logic                            valid;
  logic                            ready;
  logic [bfa_pkg::VALUE_W-1:0]     read_value;
  logic                            saturated;
  logic                            out_of_range;
  logic [bfa_pkg::NEXT_W-1:0]      next_offset;

  modport source (output valid, read_value, saturated, out_of_range, next_offset,
                  input ready);
  modport sink (input valid, read_value, saturated, out_of_range, next_offset,
                output ready);
endinterface

// ===== rtl/bit_field_buffer_access.sv =====
`timescale 1ns / 1ps
// msb-first bit field insert / extract over a byte store
// in_chan: one access per transfer (kind 0 reads, kind 1 writes a field of
//   field_width bits whose msb sits at store bit bit_offset)
// out_chan: one result per access, in order: read_value, saturated flag,
//   out_of_range flag and next_offset (bit just after the field)
// the store is held as 32-bit words in an even and an odd bank, so any field
//   touches one word of each; the back end takes one access at a time: it
//   reads both banks, then merges, writes back and registers the result
// a 2-entry queue between the classifying front end and the back end lets
//   the input keep transferring while a result waits on a stalled receiver;
//   when the queue is full, in_chan.ready drops
// reset: a clearing pass zeroes the store, one word per bank per cycle, over
//   STORE_BYTES / 8 + 1 words per bank (rounded up), during which in_chan.ready is low
module bit_field_buffer_access #(
  parameter int STORE_BYTES    = bfa_pkg::DEF_STORE_BYTES,
  parameter int MAX_FIELD_BITS = bfa_pkg::DEF_MAX_FIELD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  bfa_in_if.sink     in_chan,
  bfa_out_if.source  out_chan
);

  // queue between front end and back end
  logic              q_push, q_full, q_pop, q_empty;
  bfa_pkg::bfa_cmd_t q_data, q_head;
  logic              clearing;

  // width clamp, range check, saturation and window shift
  bfa_front #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_front (
    .in_chan  (in_chan),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  bfa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // store banks, read-modify-write and output register
  bfa_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/bfa_ram.sv =====
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bfa_fifo.sv =====
`timescale 1ns / 1ps
module bfa_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfa_pkg::bfa_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output bfa_pkg::bfa_cmd_t head,
  output logic              empty
);

  bfa_pkg::bfa_cmd_t entry_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/bfa_front.sv =====
`timescale 1ns / 1ps
module bfa_front #(
  parameter int STORE_BYTES    = bfa_pkg::DEF_STORE_BYTES,
  parameter int MAX_FIELD_BITS = bfa_pkg::DEF_MAX_FIELD_BITS
) (
  bfa_in_if.sink            in_chan,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output bfa_pkg::bfa_cmd_t q_data
);

  localparam int STORE_BITS = STORE_BYTES * 8;

  logic [bfa_pkg::FWIDTH_W-1:0] eff_w;
  logic [bfa_pkg::NEXT_W-1:0]   end_bit;
  logic [32:0]                  max_val;
  logic                         too_big;

  assign in_chan.ready = !q_full && !clearing;
  assign q_push        = in_chan.valid && in_chan.ready;

  always_comb begin
    eff_w = (in_chan.field_width > bfa_pkg::FWIDTH_W'(MAX_FIELD_BITS))
          ? bfa_pkg::FWIDTH_W'(MAX_FIELD_BITS) : in_chan.field_width;
    end_bit = bfa_pkg::NEXT_W'(in_chan.bit_offset) + bfa_pkg::NEXT_W'(eff_w);
    max_val = (33'h1 << eff_w) - 33'h1;
    too_big = {1'b0, in_chan.write_value} > max_val;

    q_data.kind        = in_chan.kind;
    q_data.oor         = 32'(end_bit) > 32'(STORE_BITS);
    q_data.sat         = (in_chan.kind == bfa_pkg::KIND_WRITE) && !q_data.oor && too_big;
    q_data.width       = eff_w;
    // right shift that brings the field to bit 0 of the two-word window
    q_data.shift       = 7'd64 - bfa_pkg::SHIFT_W'(in_chan.bit_offset[4:0])
                       - bfa_pkg::SHIFT_W'(eff_w);
    q_data.value       = too_big ? max_val[31:0] : in_chan.write_value;
    q_data.word        = in_chan.bit_offset[bfa_pkg::OFFSET_W-1:5];
    q_data.next_offset = end_bit;
  end

endmodule

// ===== rtl/bfa_back.sv =====
`timescale 1ns / 1ps
module bfa_back #(
  parameter int STORE_BYTES = bfa_pkg::DEF_STORE_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bfa_pkg::bfa_cmd_t q_head,
  output logic              q_pop,
  output logic              clearing,
  bfa_out_if.source         out_chan
);

  // two banks of 32-bit words: even words and odd words, so a field
  // spanning two neighboring words reads both in the same cycle
  localparam int BANK_DEPTH = (STORE_BYTES + 7) / 8 + 1;
  localparam int AW         = $clog2(BANK_DEPTH);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;
  bfa_pkg::bfa_cmd_t            cmd_r, cmd_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [bfa_pkg::VALUE_W-1:0]  rd_val_r, rd_val_nxt;
  logic                         sat_r, sat_nxt;
  logic                         oor_r, oor_nxt;
  logic [bfa_pkg::NEXT_W-1:0]   next_r, next_nxt;

  bfa_pkg::bfa_cmd_t            acc;
  logic [bfa_pkg::WORD_IDX_W:0] even_word;
  logic [31:0]                  even_addr32, odd_addr32;
  logic [AW-1:0]                even_addr, odd_addr;
  logic [31:0]                  even_rdata, odd_rdata;
  logic [31:0]                  even_wdata, odd_wdata;
  logic                         we, re;
  logic [63:0]                  window, mask64, new_window, field64;
  logic                         advance;

  // address source: queue head when issuing the read, held command when writing
  assign acc       = (state_r == S_IDLE) ? q_head : cmd_r;
  assign even_word = {1'b0, acc.word} + {{bfa_pkg::WORD_IDX_W{1'b0}}, acc.word[0]};
  assign even_addr32 = 32'(even_word[bfa_pkg::WORD_IDX_W:1]);
  assign odd_addr32  = 32'(acc.word[bfa_pkg::WORD_IDX_W-1:1]);

  always_comb begin
    even_addr = even_addr32[AW-1:0];
    odd_addr  = odd_addr32[AW-1:0];
    if (state_r == S_CLEAR) begin
      even_addr = clr_addr_r;
      odd_addr  = clr_addr_r;
    end
  end

  always_comb begin
    window     = cmd_r.word[0] ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};
    mask64     = (64'h1 << cmd_r.width) - 64'h1;
    field64    = (window >> cmd_r.shift) & mask64;
    new_window = (window & ~(mask64 << cmd_r.shift))
               | (({32'b0, cmd_r.value} & mask64) << cmd_r.shift);
    even_wdata = cmd_r.word[0] ? new_window[31:0] : new_window[63:32];
    odd_wdata  = cmd_r.word[0] ? new_window[63:32] : new_window[31:0];
    if (state_r == S_CLEAR) begin
      even_wdata = '0;
      odd_wdata  = '0;
    end
  end

  assign advance  = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign re       = q_pop;
  assign we       = (state_r == S_CLEAR)
                 || (advance && (cmd_r.kind == bfa_pkg::KIND_WRITE) && !cmd_r.oor);
  assign clearing = (state_r == S_CLEAR);

  bfa_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_even (
    .clk   (clk),
    .we    (we),
    .waddr (even_addr),
    .wdata (even_wdata),
    .re    (re),
    .raddr (even_addr),
    .rdata (even_rdata)
  );

  bfa_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_odd (
    .clk   (clk),
    .we    (we),
    .waddr (odd_addr),
    .wdata (odd_wdata),
    .re    (re),
    .raddr (odd_addr),
    .rdata (odd_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    rd_val_nxt    = rd_val_r;
    sat_nxt       = sat_r;
    oor_nxt       = oor_r;
    next_nxt      = next_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(BANK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          cmd_nxt   = q_head;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          rd_val_nxt    = ((cmd_r.kind == bfa_pkg::KIND_READ) && !cmd_r.oor)
                        ? field64[31:0] : '0;
          sat_nxt       = cmd_r.sat;
          oor_nxt       = cmd_r.oor;
          next_nxt      = cmd_r.next_offset;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    rd_val_r <= rd_val_nxt;
    sat_r    <= sat_nxt;
    oor_r    <= oor_nxt;
    next_r   <= next_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_value   = rd_val_r;
  assign out_chan.saturated    = sat_r;
  assign out_chan.out_of_range = oor_r;
  assign out_chan.next_offset  = next_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bfa_pkg::*;

  localparam int STORE_BYTES = DEF_STORE_BYTES;
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int MAX_BITS    = DEF_MAX_FIELD_BITS;
  localparam int PHASE_ITEMS = 456;

  // one field access as offered on the input channel
  typedef struct {
    bit                kind;
    bit [OFFSET_W-1:0] bit_offset;
    bit [FWIDTH_W-1:0] field_width;
    bit [VALUE_W-1:0]  write_value;
  } access_t;

  // what the block should answer for one access
  typedef struct {
    bit [VALUE_W-1:0] read_value;
    bit               saturated;
    bit               out_of_range;
    bit [NEXT_W-1:0]  next_offset;
  } field_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bfa_in_if  in_if ();
  bfa_out_if out_if ();

  bit_field_buffer_access dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #1 clk = ~clk;

  // shadow copy of the message store
  bit [7:0] message_bytes [STORE_BYTES];

  access_t       pending_accesses[$];
  field_result_t expected_results[$];
  access_t       in_cur;
  bit            in_held = 1'b0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            error_count = 0;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // insert or extract one field, msb first, and update the shadow store
  function automatic field_result_t apply_access(access_t a);
    field_result_t     r;
    int unsigned       eff;
    int unsigned       end_bit;
    int unsigned       pos;
    longint unsigned   max_value;
    longint unsigned   value;
    r = '{default: '0};
    eff = (a.field_width > MAX_BITS) ? MAX_BITS : a.field_width;
    end_bit = a.bit_offset + eff;
    r.next_offset = end_bit[NEXT_W-1:0];
    if (end_bit > STORE_BITS) begin
      r.out_of_range = 1'b1;
    end else if (a.kind == KIND_READ) begin
      for (int i = 0; i < eff; i++) begin
        pos = a.bit_offset + i;
        r.read_value = {r.read_value[VALUE_W-2:0], message_bytes[pos >> 3][7 - (pos & 7)]};
      end
    end else begin
      max_value = (64'd1 << eff) - 1;
      value = a.write_value;
      if (value > max_value) begin
        value = max_value;
        r.saturated = 1'b1;
      end
      for (int i = 0; i < eff; i++) begin
        pos = a.bit_offset + i;
        message_bytes[pos >> 3][7 - (pos & 7)] = value[eff - 1 - i];
      end
    end
    return r;
  endfunction

  task automatic add_access(bit kind, int unsigned off, int unsigned width,
                            bit [VALUE_W-1:0] value);
    access_t a;
    a.kind = kind;
    a.bit_offset = off;
    a.field_width = width;
    a.write_value = value;
    pending_accesses = {pending_accesses, a};
  endtask

  // random access: offsets mostly in a small window so reads find written data,
  // some near the end of the store, values mostly fitting their width
  task automatic add_random_access();
    int unsigned      off;
    int unsigned      width;
    int unsigned      eff;
    int unsigned      sel;
    bit [VALUE_W-1:0] mask;
    bit [VALUE_W-1:0] value;
    sel = $urandom_range(99);
    if (sel < 70) off = $urandom_range(511);
    else if (sel < 85) off = $urandom_range(STORE_BITS - 1, STORE_BITS - 68);
    else off = $urandom_range(STORE_BITS - 1);
    sel = $urandom_range(99);
    if (sel < 80) width = $urandom_range(MAX_BITS, 1);
    else if (sel < 88) width = 0;
    else width = $urandom_range(63, MAX_BITS + 1);
    eff = (width > MAX_BITS) ? MAX_BITS : width;
    mask = (eff == 0) ? '0 : ({VALUE_W{1'b1}} >> (VALUE_W - eff));
    sel = $urandom_range(99);
    if (sel < 55) value = $urandom & mask;
    else if (sel < 70) value = mask;
    else if (sel < 80) value = mask + 1;
    else value = $urandom;
    add_access($urandom_range(1), off, width, value);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_held) begin
        if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_cur = pending_accesses.pop_front();
          in_held = 1'b1;
          in_if.valid <= 1'b1;
          in_if.kind <= in_cur.kind;
          in_if.bit_offset <= in_cur.bit_offset;
          in_if.field_width <= in_cur.field_width;
          in_if.write_value <= in_cur.write_value;
        end else begin
          // idle cycle, payload is junk the block must ignore
          in_if.valid <= 1'b0;
          in_if.kind <= $urandom_range(1);
          in_if.bit_offset <= $urandom;
          in_if.field_width <= $urandom;
          in_if.write_value <= $urandom;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: transfers are seen on the rising edge
  always @(posedge clk) begin
    field_result_t exp_r;
    field_result_t new_r;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        new_r = apply_access(in_cur);
        expected_results = {expected_results, new_r};
        in_held = 1'b0;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_if.read_value !== exp_r.read_value)
            report($sformatf("read_value got %h expected %h",
                             out_if.read_value, exp_r.read_value));
          if (out_if.saturated !== exp_r.saturated)
            report($sformatf("saturated got %b expected %b",
                             out_if.saturated, exp_r.saturated));
          if (out_if.out_of_range !== exp_r.out_of_range)
            report($sformatf("out_of_range got %b expected %b",
                             out_if.out_of_range, exp_r.out_of_range));
          if (out_if.next_offset !== exp_r.next_offset)
            report($sformatf("next_offset got %0d expected %0d",
                             out_if.next_offset, exp_r.next_offset));
        end
      end
    end
  end

  initial begin
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 86, 0, 37};
    recv_pct = '{0, 0, 86, 37};
    for (int i = 0; i < STORE_BYTES; i++) message_bytes[i] = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_READ;
    in_if.bit_offset = '0;
    in_if.field_width = '0;
    in_if.write_value = '0;
    out_if.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: cleared store, field extremes, clamping, empty fields, store end
    add_access(KIND_READ, 0, 32, 32'h0);
    add_access(KIND_WRITE, 0, 32, 32'hffff_ffff);
    add_access(KIND_READ, 0, 32, 32'h0);
    add_access(KIND_WRITE, 3, 1, 32'h0);
    add_access(KIND_READ, 0, 8, 32'h0);
    add_access(KIND_WRITE, 10, 5, 32'd32);
    add_access(KIND_WRITE, 40, 0, 32'd5);
    add_access(KIND_READ, 40, 0, 32'h0);
    add_access(KIND_WRITE, 100, 63, 32'h1234_5678);
    add_access(KIND_READ, 100, 33, 32'h0);
    add_access(KIND_WRITE, STORE_BITS - 1, 1, 32'd1);
    add_access(KIND_READ, STORE_BITS - 8, 8, 32'h0);
    add_access(KIND_WRITE, STORE_BITS - 1, 2, 32'd3);
    add_access(KIND_READ, STORE_BITS - 1, 2, 32'h0);
    add_access(KIND_WRITE, STORE_BITS - 32, 32, 32'ha5a5_a5a5);
    add_access(KIND_READ, STORE_BITS - 32, 32, 32'h0);
    add_access(KIND_READ, STORE_BITS - 31, 32, 32'h0);
    add_access(KIND_READ, STORE_BITS - 1, 63, 32'hffff_ffff);
    add_access(KIND_WRITE, 7, 32, 32'hdead_beef);
    add_access(KIND_READ, 7, 32, 32'h0);
    add_access(KIND_READ, 0, 16, 32'h0);
    add_access(KIND_WRITE, 200, 4, 32'd15);
    add_access(KIND_WRITE, 204, 4, 32'd16);
    add_access(KIND_READ, 200, 8, 32'h0);
    add_access(KIND_WRITE, STORE_BITS - 1, 0, 32'd7);

    // each idling phase drains fully before the next, so the sender also
    // pauses until every expected result is back
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int n = 0; n < PHASE_ITEMS; n++) add_random_access();
      while (pending_accesses.size() > 0 || in_held || expected_results.size() > 0)
        @(negedge clk);
    end

    // catch any stray result after the last one
    repeat (40) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_ram.sv
rtl/bfa_fifo.sv
rtl/bfa_front.sv
rtl/bfa_back.sv
rtl/bit_field_buffer_access.sv
dv/testbench.sv
